FILE: sv/modular_arithmetic_unit_assert.svh
// Assertion macros shared by the modular arithmetic unit RTL.
`ifndef MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define MAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mau_pkg.sv
// Shared widths, codes and types of the modular arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package mau_pkg;

    localparam int OP_W        = 63;
    localparam int RES_W       = 30;
    localparam int MODE_W      = 3;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 32;
    localparam int RED_CNT_W   = $clog2(OP_W);
    localparam int MUL_CNT_W   = $clog2(RES_W);

    localparam logic [RES_W-1:0] MODULUS_RESET = 30'd1000000007;

    localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POW = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INV = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DIV = 3'd5;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

FILE: sv/mau_modmul.sv
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps
`default_nettype none

module mau_modmul
    import mau_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [RES_W-1:0] x,
    input  wire logic [RES_W-1:0] y,
    input  wire logic [RES_W-1:0] m,
    output logic      [RES_W-1:0] prod,
    output unit_stat_t            stat
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RES_W-1:0]     x_reg, x_next;
    logic [RES_W-1:0]     y_reg, y_next;
    logic [RES_W-1:0]     acc_reg, acc_next;

    logic [RES_W+1:0] t, m1, m2, step;

    // acc < m, so 2*acc + x < 3m: at most two subtractions
    always_comb
    begin
        m1 = {2'b00, m};
        m2 = {1'b0, m, 1'b0};
        t  = {1'b0, acc_reg, 1'b0} + (y_reg[RES_W-1] ? {2'b00, x_reg} : '0);
        if (t >= m2)
        begin
            step = t - m2;
        end
        else if (t >= m1)
        begin
            step = t - m1;
        end
        else
        begin
            step = t;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = MUL_CNT_W'(RES_W - 1);
            x_next    = x;
            y_next    = y;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = step[RES_W-1:0];
            y_next   = {y_reg[RES_W-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    assign prod      = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

FILE: sv/mau_reduce.sv
// Bit-serial reduction of a wide operand modulo the modulus, MSB first.
`timescale 1ns / 1ps
`default_nettype none

module mau_reduce
    import mau_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [OP_W-1:0]  val,
    input  wire logic [RES_W-1:0] m,
    output logic      [RES_W-1:0] rem,
    output unit_stat_t            stat
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [RED_CNT_W-1:0] cnt_reg, cnt_next;
    logic [OP_W-1:0]      sh_reg, sh_next;
    logic [RES_W-1:0]     rem_reg, rem_next;

    logic [RES_W:0] t, step;

    // rem < m, so 2*rem + 1 < 2m
    always_comb
    begin
        t = {rem_reg, sh_reg[OP_W-1]};
        if (t >= {1'b0, m})
        begin
            step = t - {1'b0, m};
        end
        else
        begin
            step = t;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = RED_CNT_W'(OP_W - 1);
            sh_next   = val;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = step[RES_W-1:0];
            sh_next  = {sh_reg[OP_W-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign rem       = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

FILE: sv/modular_arithmetic_unit.sv
// Modular arithmetic unit: add, subtract, multiply, power, inverse, divide.
//
// One word in, one residue out. Both operands are first reduced bit-serially,
// one after the other; add and subtract then take their result from the adder.
// A multiply runs through the bit-serial multiplier. Power, inverse and divide
// walk all 63 exponent bits, squaring each time and multiplying when the bit
// is set, with one more multiply for divide. Only one word is in flight: a new
// word is taken only once the last result is loaded into the output register.
// A modulus below two, and modes 6 and 7, give 0 without any reduction.
// The modulus may be written only while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "modular_arithmetic_unit_assert.svh"

module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [62:0] operand_a, [125:63] operand_b, [127:126] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] mode
    input  wire logic [MODE_W-1:0]      s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [29:0] result, [31:30] zero
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [RES_W-1:0]       cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RED_A = 4'd1;
    localparam logic [3:0] S_RED_B = 4'd2;
    localparam logic [3:0] S_OP    = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_SQ_W  = 4'd5;
    localparam logic [3:0] S_ML_W  = 4'd6;
    localparam logic [3:0] S_NEXT  = 4'd7;
    localparam logic [3:0] S_FIN_W = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [OP_W-1:0]      b_raw_reg, b_raw_next;
    logic [RES_W-1:0]     a_red_reg, a_red_next;
    logic [RES_W-1:0]     b_red_reg, b_red_next;
    logic [RES_W-1:0]     base_reg, base_next;
    logic [RES_W-1:0]     acc_reg, acc_next;
    logic [RES_W-1:0]     res_reg, res_next;
    logic [OP_W-1:0]      exp_reg, exp_next;
    logic [RED_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [RES_W-1:0]     modulus_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [RES_W-1:0]     out_data_reg, out_data_next;

    logic             red_start;
    logic [OP_W-1:0]  red_val;
    logic [RES_W-1:0] red_rem;
    unit_stat_t       red_stat;

    logic             mul_start;
    logic [RES_W-1:0] mul_x, mul_y, mul_prod;
    unit_stat_t       mul_stat;

    logic             out_load;
    logic [RES_W:0]   sum, sum_red;
    logic [OP_W-1:0]  exp_inv;

    mau_reduce u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .start (red_start),
        .val   (red_val),
        .m     (modulus_reg),
        .rem   (red_rem),
        .stat  (red_stat)
    );

    mau_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .m     (modulus_reg),
        .prod  (mul_prod),
        .stat  (mul_stat)
    );

    // a + b or a + (m - b), then one correction
    always_comb
    begin
        if (mode_reg == MODE_SUB)
        begin
            sum = {1'b0, a_red_reg} + {1'b0, modulus_reg - b_red_reg};
        end
        else
        begin
            sum = {1'b0, a_red_reg} + {1'b0, b_red_reg};
        end
        if (sum >= {1'b0, modulus_reg})
        begin
            sum_red = sum - {1'b0, modulus_reg};
        end
        else
        begin
            sum_red = sum;
        end
    end

    assign exp_inv = {{(OP_W - RES_W){1'b0}}, modulus_reg - RES_W'(2)};

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        b_raw_next   = b_raw_reg;
        a_red_next   = a_red_reg;
        b_red_next   = b_red_reg;
        base_next    = base_reg;
        acc_next     = acc_reg;
        res_next     = res_reg;
        exp_next     = exp_reg;
        bit_cnt_next = bit_cnt_reg;
        red_start    = 1'b0;
        red_val      = b_raw_reg;
        mul_start    = 1'b0;
        mul_x        = acc_reg;
        mul_y        = acc_reg;
        out_load     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next  = s_axis_tuser;
                    b_raw_next = s_axis_tdata[2*OP_W-1:OP_W];
                    if (modulus_reg < RES_W'(2) || s_axis_tuser > MODE_DIV)
                    begin
                        res_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        red_start  = 1'b1;
                        red_val    = s_axis_tdata[OP_W-1:0];
                        state_next = S_RED_A;
                    end
                end
            end
            S_RED_A:
            begin
                if (red_stat.done)
                begin
                    a_red_next = red_rem;
                    red_start  = 1'b1;
                    state_next = S_RED_B;
                end
            end
            S_RED_B:
            begin
                if (red_stat.done)
                begin
                    b_red_next = red_rem;
                    state_next = S_OP;
                end
            end
            S_OP:
            begin
                acc_next     = RES_W'(1);
                bit_cnt_next = RED_CNT_W'(OP_W - 1);
                case (mode_reg)
                    MODE_ADD, MODE_SUB:
                    begin
                        res_next   = sum_red[RES_W-1:0];
                        state_next = S_OUT;
                    end
                    MODE_MUL:
                    begin
                        mul_start  = 1'b1;
                        mul_x      = a_red_reg;
                        mul_y      = b_red_reg;
                        state_next = S_FIN_W;
                    end
                    MODE_POW:
                    begin
                        base_next  = a_red_reg;
                        exp_next   = b_raw_reg;
                        state_next = S_SQ;
                    end
                    MODE_INV:
                    begin
                        base_next = a_red_reg;
                        exp_next  = exp_inv;
                        if (a_red_reg == '0)
                        begin
                            res_next   = '0;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_SQ;
                        end
                    end
                    MODE_DIV:
                    begin
                        base_next = b_red_reg;
                        exp_next  = exp_inv;
                        if (b_red_reg == '0)
                        begin
                            res_next   = '0;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_SQ;
                        end
                    end
                    default:
                    begin
                        res_next   = '0;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_SQ:
            begin
                mul_start  = 1'b1;
                state_next = S_SQ_W;
            end
            S_SQ_W:
            begin
                if (mul_stat.done)
                begin
                    acc_next = mul_prod;
                    if (exp_reg[OP_W-1])
                    begin
                        mul_start  = 1'b1;
                        mul_x      = mul_prod;
                        mul_y      = base_reg;
                        state_next = S_ML_W;
                    end
                    else
                    begin
                        state_next = S_NEXT;
                    end
                end
            end
            S_ML_W:
            begin
                if (mul_stat.done)
                begin
                    acc_next   = mul_prod;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                exp_next = {exp_reg[OP_W-2:0], 1'b0};
                if (bit_cnt_reg == '0)
                begin
                    if (mode_reg == MODE_DIV)
                    begin
                        mul_start  = 1'b1;
                        mul_x      = a_red_reg;
                        mul_y      = acc_reg;
                        state_next = S_FIN_W;
                    end
                    else
                    begin
                        res_next   = acc_reg;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                    state_next   = S_SQ;
                end
            end
            S_FIN_W:
            begin
                if (mul_stat.done)
                begin
                    res_next   = mul_prod;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_data_next = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_axis_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= MODULUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                modulus_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        b_raw_reg    <= b_raw_next;
        a_red_reg    <= a_red_next;
        b_red_reg    <= b_red_next;
        base_reg     <= base_next;
        acc_reg      <= acc_next;
        res_reg      <= res_next;
        exp_reg      <= exp_next;
        bit_cnt_reg  <= bit_cnt_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, out_data_reg};

    `MAU_ASSERT_NOW(a_res_below_mod, m_axis_tvalid && modulus_reg >= 30'd2, m_axis_tdata[29:0] < modulus_reg, "result word not below modulus")
    `MAU_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken while busy")
    `MAU_ASSERT_NOW(a_mul_start_idle, mul_start, !mul_stat.busy, "multiplier started while busy")
    `MAU_ASSERT_NOW(a_red_start_idle, red_start, !red_stat.busy, "reducer started while busy")

endmodule

`default_nettype wire
